FILE: rtl/length_prefixed_packet_deframer_top_defines.svh
// Assertion macros shared by the deframer modules.
`ifndef LENGTH_PREFIXED_PACKET_DEFRAMER_TOP_DEFINES_SVH
`define LENGTH_PREFIXED_PACKET_DEFRAMER_TOP_DEFINES_SVH

// Clocked check, masked while reset is held.
`define LPD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Clocked check that also holds during reset.
`define LPD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/lpd_pkg.sv
// Shared types and constants of the length-prefixed packet deframer.
package lpd_pkg;

  localparam int QDEPTH = 4;
  localparam int QAW = $clog2(QDEPTH);

  localparam logic [16:0] MAX_LEN_RESET = 17'h10000;

  typedef enum logic [1:0] {
    KIND_DATA      = 2'd0,
    KIND_EMPTY     = 2'd1,
    KIND_TOO_LARGE = 2'd2
  } kind_t;

  typedef enum logic [5:0] {
    PH_HDR0 = 6'b000001,
    PH_HDR1 = 6'b000010,
    PH_HDR2 = 6'b000100,
    PH_HDR3 = 6'b001000,
    PH_BODY = 6'b010000,
    PH_HALT = 6'b100000
  } phase_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data;
    logic [15:0] protocol;
    logic [15:0] length;
    logic        first;
    logic        last;
  } res_t;

endpackage

FILE: rtl/lpd_front.sv
// Front end: header parser and byte classifier, one byte per clock while the queue is not full.
`include "length_prefixed_packet_deframer_top_defines.svh"
module lpd_front
  import lpd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [16:0] cfg_wdata,
  input  logic        in_push,
  input  logic [7:0]  in_byte,
  input  logic        full_i,
  output logic        push_o,
  output res_t        res_o
);

  phase_t      phase_r, phase_nxt;
  logic [15:0] len_r, len_nxt;
  logic [15:0] proto_r, proto_nxt;
  logic [15:0] rem_r, rem_nxt;
  logic [16:0] max_r;
  logic [15:0] proto_word;
  logic        accept;
  logic        last_byte;

  assign accept     = in_push && !full_i;
  assign proto_word = {in_byte, proto_r[7:0]};
  assign last_byte  = (rem_r <= 16'd1);

  always_comb begin
    phase_nxt = phase_r;
    len_nxt   = len_r;
    proto_nxt = proto_r;
    rem_nxt   = rem_r;
    push_o    = 1'b0;
    res_o.kind     = KIND_DATA;
    res_o.data     = 8'h00;
    res_o.protocol = proto_r;
    res_o.length   = len_r;
    res_o.first    = 1'b1;
    res_o.last     = 1'b1;
    if (accept) begin
      case (phase_r)
        PH_HDR0: begin
          len_nxt   = {8'h00, in_byte};
          phase_nxt = PH_HDR1;
        end
        PH_HDR1: begin
          len_nxt   = {in_byte, len_r[7:0]};
          phase_nxt = PH_HDR2;
        end
        PH_HDR2: begin
          proto_nxt = {8'h00, in_byte};
          phase_nxt = PH_HDR3;
        end
        PH_HDR3: begin
          proto_nxt      = proto_word;
          res_o.protocol = proto_word;
          if ({1'b0, len_r} >= max_r) begin
            // oversize request: report once, then stop until reset
            res_o.kind = KIND_TOO_LARGE;
            push_o     = 1'b1;
            phase_nxt  = PH_HALT;
          end else if (len_r == 16'd0) begin
            res_o.kind = KIND_EMPTY;
            push_o     = 1'b1;
            proto_nxt  = 16'd0;
            phase_nxt  = PH_HDR0;
          end else begin
            rem_nxt   = len_r;
            phase_nxt = PH_BODY;
          end
        end
        PH_BODY: begin
          res_o.kind  = KIND_DATA;
          res_o.data  = in_byte;
          res_o.first = (rem_r == len_r);
          res_o.last  = last_byte;
          push_o      = 1'b1;
          rem_nxt     = rem_r - 16'd1;
          if (last_byte) begin
            rem_nxt   = 16'd0;
            len_nxt   = 16'd0;
            proto_nxt = 16'd0;
            phase_nxt = PH_HDR0;
          end
        end
        default: begin
          phase_nxt = phase_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HDR0;
      len_r   <= 16'd0;
      proto_r <= 16'd0;
      rem_r   <= 16'd0;
      max_r   <= MAX_LEN_RESET;
    end else begin
      phase_r <= phase_nxt;
      len_r   <= len_nxt;
      proto_r <= proto_nxt;
      rem_r   <= rem_nxt;
      if (cfg_we) begin
        max_r <= cfg_wdata;
      end
    end
  end

  `LPD_ASSERT(a_halt_sticks, phase_r == PH_HALT |=> phase_r == PH_HALT, "left halt state")
  `LPD_ASSERT(a_body_rem_nonzero, phase_r == PH_BODY |-> rem_r != 16'd0, "body with no bytes left")

endmodule

FILE: rtl/lpd_fifo.sv
// Short request queue between the classifier and the output stage.
`include "length_prefixed_packet_deframer_top_defines.svh"
module lpd_fifo
  import lpd_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push_i,
  input  res_t wdata_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output res_t rdata_o
);

  res_t           mem_r [QDEPTH];
  logic [QAW-1:0] wptr_r, rptr_r;
  logic [QAW:0]   count_r, count_nxt;
  logic           do_push, do_pop;

  assign full_o  = (count_r == (QAW+1)'(QDEPTH));
  assign valid_o = (count_r != '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;
  assign rdata_o = mem_r[rptr_r];

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= wdata_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
      if (do_push) begin
        wptr_r <= wptr_r + 1'b1;
      end
      if (do_pop) begin
        rptr_r <= rptr_r + 1'b1;
      end
    end
  end

  `LPD_ASSERT(a_count_bound, count_r <= (QAW+1)'(QDEPTH), "queue count overflow")
  `LPD_ASSERT(a_ptr_gap, !full_o |-> (wptr_r - rptr_r) == count_r[QAW-1:0], "pointer/count mismatch")

endmodule

FILE: rtl/lpd_back.sv
// Back end: output register that presents the oldest request.
`include "length_prefixed_packet_deframer_top_defines.svh"
module lpd_back
  import lpd_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic q_valid_i,
  input  res_t q_data_i,
  output logic q_pop_o,
  input  logic out_pop,
  output logic out_empty,
  output res_t out_res_o
);

  logic out_valid_r;
  res_t res_r;

  // refill whenever the register is free or being drained this cycle
  assign q_pop_o   = q_valid_i && (!out_valid_r || out_pop);
  assign out_empty = !out_valid_r;
  assign out_res_o = res_r;

  always_ff @(posedge clk) begin
    if (q_pop_o) begin
      res_r <= q_data_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (q_pop_o) begin
      out_valid_r <= 1'b1;
    end else if (out_pop) begin
      out_valid_r <= 1'b0;
    end
  end

  `LPD_ASSERT(a_refill, out_valid_r && out_pop && q_valid_i |=> out_valid_r, "output stage bubble")
  `LPD_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> out_empty, "output not empty after reset")

endmodule

FILE: rtl/length_prefixed_packet_deframer_top.sv
// Length-prefixed packet deframer: top level.
// Input is a byte queue: drive in_byte and in_push; a byte is taken on a
// clock edge where in_push is high and in_full is low. Each packet is a
// four-byte header (16-bit little-endian length, 16-bit little-endian
// protocol id) followed by that many payload bytes.
// Results come out as a queue: while out_empty is low the oldest request
// is on the out_ ports; out_pop takes it. One request per payload byte,
// one for an empty packet, one for a length at or above the configured
// maximum, after which all input is dropped until reset.
// cfg_we/cfg_wdata write the maximum length (reset 65536); write only
// when idle.
// Throughput is one byte per clock while in_full is low, set by the
// combinational classifier. A byte's request is written into the queue
// when the byte is accepted and then moved into the output register
// when nothing older is waiting. When the receiver stalls, up to five
// requests are held before in_full rises. Synchronous reset clears parser
// state and empties the queue.
module length_prefixed_packet_deframer_top
  import lpd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [16:0] cfg_wdata,
  input  logic        in_push,
  input  logic [7:0]  in_byte,
  output logic        in_full,
  input  logic        out_pop,
  output logic        out_empty,
  output logic [1:0]  out_result_kind,
  output logic [7:0]  out_data_byte,
  output logic [15:0] out_packet_protocol,
  output logic [15:0] out_packet_length,
  output logic        out_is_first,
  output logic        out_is_last
);

  logic front_push;
  res_t front_res;
  logic q_valid;
  res_t q_data;
  logic q_pop;
  res_t out_res;

  lpd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_push   (in_push),
    .in_byte   (in_byte),
    .full_i    (in_full),
    .push_o    (front_push),
    .res_o     (front_res)
  );

  lpd_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (front_push),
    .wdata_i (front_res),
    .full_o  (in_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .rdata_o (q_data)
  );

  lpd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid_i (q_valid),
    .q_data_i  (q_data),
    .q_pop_o   (q_pop),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_res_o (out_res)
  );

  assign out_result_kind     = out_res.kind;
  assign out_data_byte       = out_res.data;
  assign out_packet_protocol = out_res.protocol;
  assign out_packet_length   = out_res.length;
  assign out_is_first        = out_res.first;
  assign out_is_last         = out_res.last;

endmodule
